// ===== rtl/msp_pkg.sv =====
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the microslice pattern generator.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int ELAPSED_W = 48;
    localparam int INDEX_W   = 64;
    localparam int SIZE_W    = 20;
    localparam int ADDR_W    = 24;
    localparam int CSUM_W    = 32;
    localparam int DELAY_W   = 32;
    localparam int SOURCE_W  = 16;
    localparam int MODE_W    = 3;
    localparam int PTABLE_W  = 28;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    // fill percentages
    localparam int PCT_W      = 7;
    localparam int PCT_VALUES = 128;
    localparam int PCT_DIV    = 100;

    // rate threshold multiplier
    localparam int RATE_CNT_W = 6;

    // mode flag bit positions
    localparam int MODE_RAMP   = 0;
    localparam int MODE_RANDOM = 1;
    localparam int MODE_FIXED  = 2;

    // result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_WORD = 2'd1;
    localparam logic [1:0] KIND_DESC = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTENT_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REFILL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PCT_TABLE    = 3'd5;

    // register reset values
    localparam logic [SIZE_W-1:0]    RST_CONTENT_SIZE = 20'd4096;
    localparam logic [DELAY_W-1:0]   RST_DELAY        = 32'd0;
    localparam logic [ELAPSED_W-1:0] RST_REFILL       = 48'd0;
    localparam logic [MODE_W-1:0]    RST_MODE         = 3'd1;
    localparam logic [SOURCE_W-1:0]  RST_SOURCE       = 16'd0;
    localparam logic [PTABLE_W-1:0]  RST_PCT_TABLE    = 28'd106956900;

    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed_ns;
        logic [INDEX_W-1:0]   read_data_index;
        logic [INDEX_W-1:0]   read_desc_index;
        logic [SIZE_W-1:0]    random_bytes;
    } msp_item_t;

    typedef struct packed {
        logic [SIZE_W-1:0]    content_size;
        logic [ELAPSED_W-1:0] refill_period_ns;
        logic [MODE_W-1:0]    mode_flags;
        logic [SOURCE_W-1:0]  source_index;
        logic [PTABLE_W-1:0]  percent_table;
    } msp_cfg_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [ADDR_W-1:0]  ring_address;
        logic [INDEX_W-1:0] data_word;
        logic [INDEX_W-1:0] slice_index;
        logic [CSUM_W-1:0]  checksum;
        logic [SIZE_W-1:0]  slice_size;
        logic [INDEX_W-1:0] slice_offset;
        logic               pattern_format;
    } msp_res_t;

    function automatic logic [PCT_W-1:0] pct_field(logic [PTABLE_W-1:0] tbl, logic [1:0] pos);
        pct_field = tbl[PCT_W*pos +: PCT_W];
    endfunction

endpackage

// ===== rtl/microslice_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// microslice_pattern_generator_unit
// Writes microslices (ramp-pattern words when the ramp mode is set) and their descriptors
// into a data ring and a descriptor ring, paced by refill epochs and a descriptor rate limit.
//
//   channel  direction  signals
//   in       input      in_valid/in_ready, elapsed_ns, read_data_index,
//                       read_desc_index, random_bytes (one word per tick)
//   out      output     out_valid/out_ready, kind, ring_address, data_word,
//                       slice_index, checksum, slice_size, slice_offset,
//                       pattern_format
//   cfg      input      cfg_we, cfg_index, cfg_data
//
// One input word per cycle while neither the output nor the rate multiplier stalls;
// a result passes through the input register, then the result register.
// A write of delay_per_slice_ns holds the input while the rate threshold
// is recomputed one delay bit per cycle.
// Reset clears the ring positions and returns the sequencer to idle.
// A stalled output holds the result register and, behind it, the input word.
// ----------------------------------------------------------------------------
module microslice_pattern_generator_unit #(
    parameter int DATA_BYTES_LOG2   = 24,
    parameter int DESC_ENTRIES_LOG2 = 16,
    parameter int PCT_ENTRIES       = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [msp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [msp_pkg::ELAPSED_W-1:0]    elapsed_ns,
    input  logic [msp_pkg::INDEX_W-1:0]      read_data_index,
    input  logic [msp_pkg::INDEX_W-1:0]      read_desc_index,
    input  logic [msp_pkg::SIZE_W-1:0]       random_bytes,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       kind,
    output logic [msp_pkg::ADDR_W-1:0]       ring_address,
    output logic [msp_pkg::INDEX_W-1:0]      data_word,
    output logic [msp_pkg::INDEX_W-1:0]      slice_index,
    output logic [msp_pkg::CSUM_W-1:0]       checksum,
    output logic [msp_pkg::SIZE_W-1:0]       slice_size,
    output logic [msp_pkg::INDEX_W-1:0]      slice_offset,
    output logic                             pattern_format
);
    import msp_pkg::*;

    msp_cfg_t           cfg_reg;
    logic [DELAY_W-1:0] delay_reg;
    msp_item_t          item_reg;
    logic               in_vld_reg;
    logic               fire;
    logic               busy;
    logic               desc_step;
    logic               res_valid;
    logic               delay_load;
    logic [INDEX_W-1:0] threshold;
    logic [INDEX_W-1:0] desc_pos;
    msp_res_t           res;

    assign delay_load = cfg_we && cfg_index == CFG_DELAY;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.content_size     <= RST_CONTENT_SIZE;
            cfg_reg.refill_period_ns <= RST_REFILL;
            cfg_reg.mode_flags       <= RST_MODE;
            cfg_reg.source_index     <= RST_SOURCE;
            cfg_reg.percent_table    <= RST_PCT_TABLE;
            delay_reg                <= RST_DELAY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTENT_SIZE: cfg_reg.content_size     <= cfg_data[SIZE_W-1:0];
                CFG_DELAY:        delay_reg                <= cfg_data[DELAY_W-1:0];
                CFG_REFILL:       cfg_reg.refill_period_ns <= cfg_data[ELAPSED_W-1:0];
                CFG_MODE:         cfg_reg.mode_flags       <= cfg_data[MODE_W-1:0];
                CFG_SOURCE:       cfg_reg.source_index     <= cfg_data[SOURCE_W-1:0];
                CFG_PCT_TABLE:    cfg_reg.percent_table    <= cfg_data[PTABLE_W-1:0];
                default:          ;
            endcase
        end
    end

    // the sequencer advances one word when one is held, the rate multiplier is idle and the result register can take it
    assign fire     = in_vld_reg && !busy && (!res_valid || out_ready);
    assign in_ready = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.elapsed_ns      <= elapsed_ns;
            item_reg.read_data_index <= read_data_index;
            item_reg.read_desc_index <= read_desc_index;
            item_reg.random_bytes    <= random_bytes;
        end
    end

    msp_rate_mult u_rate (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (delay_load),
        .load_delay (cfg_data[DELAY_W-1:0]),
        .delay      (delay_reg),
        .desc_pos   (desc_pos),
        .step       (desc_step),
        .threshold  (threshold),
        .busy       (busy)
    );

    msp_core #(
        .DATA_BYTES_LOG2   (DATA_BYTES_LOG2),
        .DESC_ENTRIES_LOG2 (DESC_ENTRIES_LOG2),
        .PCT_ENTRIES       (PCT_ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .out_ready (out_ready),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .threshold (threshold),
        .desc_pos  (desc_pos),
        .desc_step (desc_step),
        .res_valid (res_valid),
        .res       (res)
    );

    assign out_valid      = res_valid;
    assign kind           = res.kind;
    assign ring_address   = res.ring_address;
    assign data_word      = res.data_word;
    assign slice_index    = res.slice_index;
    assign checksum       = res.checksum;
    assign slice_size     = res.slice_size;
    assign slice_offset   = res.slice_offset;
    assign pattern_format = res.pattern_format;

endmodule

// ===== rtl/msp_rate_mult.sv =====
// ----------------------------------------------------------------------------
// msp_rate_mult
// Keeps the saturated descriptor rate threshold delay * descriptor count.
// Steps by one delay per descriptor; a delay write recomputes it bit-serially.
// ----------------------------------------------------------------------------
module msp_rate_mult (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [msp_pkg::DELAY_W-1:0]   load_delay,
    input  logic [msp_pkg::DELAY_W-1:0]   delay,
    input  logic [msp_pkg::INDEX_W-1:0]   desc_pos,
    input  logic                          step,
    output logic [msp_pkg::INDEX_W-1:0]   threshold,
    output logic                          busy
);
    import msp_pkg::*;

    logic [INDEX_W-1:0]    req_reg, req_next;
    logic [DELAY_W-1:0]    bits_reg, bits_next;
    logic [RATE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  sat_reg, sat_next;
    logic [INDEX_W+1:0]    mac;
    logic                  mac_ovf;
    logic [INDEX_W:0]      acc;

    always_comb
    begin
        // msb first: acc = 2*acc + bit*desc_pos
        mac      = {1'b0, req_reg, 1'b0} + (INDEX_W+2)'(bits_reg[DELAY_W-1] ? desc_pos : '0);
        mac_ovf  = |mac[INDEX_W+1:INDEX_W];
        acc      = {1'b0, req_reg} + (INDEX_W+1)'(delay);
        req_next  = req_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sat_next  = sat_reg;
        if (load)
        begin
            req_next  = '0;
            bits_next = load_delay;
            cnt_next  = RATE_CNT_W'(DELAY_W);
            busy_next = 1'b1;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            bits_next = {bits_reg[DELAY_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            sat_next  = sat_reg | mac_ovf;
            req_next  = mac[INDEX_W-1:0];
            if (cnt_reg == RATE_CNT_W'(1))
            begin
                busy_next = 1'b0;
                if (sat_reg || mac_ovf)
                begin
                    req_next = '1;
                end
            end
        end
        else if (step)
        begin
            req_next = acc[INDEX_W] ? '1 : acc[INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg  <= '0;
            bits_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            req_reg  <= req_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            sat_reg  <= sat_next;
        end
    end

    assign threshold = req_reg;
    assign busy      = busy_reg;

`ifndef SYNTHESIS
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == '0)
        else $error("rate multiplier idle with nonzero count");
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && cnt_reg == RATE_CNT_W'(DELAY_W))
        else $error("rate multiplier did not start on delay write");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !load |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("rate multiplier count skipped");
`endif

endmodule

// ===== rtl/msp_core.sv =====
// ----------------------------------------------------------------------------
// msp_core
// Slice sequencer and datapath: refill targets, slice start checks,
// ramp words, descriptors, and the result register.
// ----------------------------------------------------------------------------
module msp_core #(
    parameter int DATA_BYTES_LOG2   = 24,
    parameter int DESC_ENTRIES_LOG2 = 16,
    parameter int PCT_ENTRIES       = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic                        out_ready,
    input  msp_pkg::msp_item_t          item,
    input  msp_pkg::msp_cfg_t           cfg,
    input  logic [msp_pkg::INDEX_W-1:0] threshold,
    output logic [msp_pkg::INDEX_W-1:0] desc_pos,
    output logic                        desc_step,
    output logic                        res_valid,
    output msp_pkg::msp_res_t           res
);
    import msp_pkg::*;

    localparam int DTW = DATA_BYTES_LOG2 + 1;
    localparam int ETW = DESC_ENTRIES_LOG2 + 1;
    localparam int DAW = (DATA_BYTES_LOG2 < ADDR_W) ? DATA_BYTES_LOG2 : ADDR_W;
    localparam int EAW = (DESC_ENTRIES_LOG2 < ADDR_W) ? DESC_ENTRIES_LOG2 : ADDR_W;
    localparam logic [INDEX_W-1:0] DCAP = 64'd1 << DATA_BYTES_LOG2;
    localparam logic [INDEX_W-1:0] ECAP = 64'd1 << DESC_ENTRIES_LOG2;
    localparam logic [1:0] PCT_LAST = 2'(PCT_ENTRIES - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FILL,
        PH_WORDS,
        PH_DESC
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [INDEX_W-1:0]   wdp_reg, wdp_next;
    logic [INDEX_W-1:0]   wdesc_reg, wdesc_next;
    logic [SIZE_W-1:0]    wo_reg, wo_next;
    logic [CSUM_W-1:0]    cs_reg, cs_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [INDEX_W-1:0]   soff_reg, soff_next;
    logic [DTW-1:0]       tgt_d_reg, tgt_d_next;
    logic [ETW-1:0]       tgt_e_reg, tgt_e_next;
    logic [ELAPSED_W-1:0] last_reg, last_next;
    logic [1:0]           pos_reg, pos_next;
    logic                 pat_reg, pat_next;
    logic                 out_vld_reg, out_vld_next;
    msp_res_t             res_reg, res_next;

    // share of capacity for each percentage, worked out at elaboration
    logic [DTW-1:0] dshare [PCT_VALUES];
    logic [ETW-1:0] eshare [PCT_VALUES];

    for (genvar p = 0; p < PCT_VALUES; p++)
    begin : g_share
        assign dshare[p] = DTW'((64'(p) << DATA_BYTES_LOG2) / 64'(PCT_DIV));
        assign eshare[p] = ETW'((64'(p) << DESC_ENTRIES_LOG2) / 64'(PCT_DIV));
    end

    logic [INDEX_W-1:0] used_d, used_e;
    logic               refill_due;
    logic [1:0]         pos_inc;
    logic [PCT_W-1:0]   pct_n, pct_0;
    logic [DTW-1:0]     sh_d_n, sh_d_0, fixed_d;
    logic [ETW-1:0]     sh_e_n, sh_e_0, fixed_e;
    logic [DTW:0]       fix_sum_d;
    logic [ETW:0]       fix_sum_e;
    logic               used_d_big, used_e_big;
    logic               fixed_mode;
    logic               hit_d_new, hit_e_new;
    logic [SIZE_W-1:0]  bytes;
    logic [INDEX_W:0]   ub;
    logic               space_fail_idle, space_fail_fill, space_fail;
    logic               rate_ok, desc_ok;
    logic               try_start, from_idle, start;
    logic               emit_word, emit_desc;
    logic [SIZE_W-1:0]  eff_wo, eff_size, wo_inc;
    logic [CSUM_W-1:0]  eff_cs;
    logic [INDEX_W-1:0] eff_soff, word;
    logic               eff_pat;
    logic               has_res;

    always_comb
    begin
        used_d     = wdp_reg - item.read_data_index;
        used_e     = wdesc_reg - item.read_desc_index;
        refill_due = ELAPSED_W'(item.elapsed_ns - last_reg) >= cfg.refill_period_ns;
        pos_inc    = (pos_reg == PCT_LAST) ? 2'd0 : pos_reg + 2'd1;
        pct_n      = pct_field(cfg.percent_table, pos_inc);
        pct_0      = pct_field(cfg.percent_table, 2'd0);
        sh_d_n     = dshare[pct_n];
        sh_d_0     = dshare[pct_0];
        sh_e_n     = eshare[pct_n];
        sh_e_0     = eshare[pct_0];
        fixed_mode = cfg.mode_flags[MODE_FIXED];
        used_d_big = used_d >= DCAP;
        used_e_big = used_e >= ECAP;

        // fixed increase: min(used + share, capacity)
        fix_sum_d = (DTW+1)'(used_d[DATA_BYTES_LOG2-1:0]) + (DTW+1)'(sh_d_0);
        fix_sum_e = (ETW+1)'(used_e[DESC_ENTRIES_LOG2-1:0]) + (ETW+1)'(sh_e_0);
        fixed_d   = (used_d_big || fix_sum_d > (DTW+1)'(DCAP)) ? DTW'(DCAP) : DTW'(fix_sum_d);
        fixed_e   = (used_e_big || fix_sum_e > (ETW+1)'(ECAP)) ? ETW'(ECAP) : ETW'(fix_sum_e);

        // use already at the new target, without waiting for the min above
        hit_d_new = fixed_mode ? (sh_d_0 == '0 || used_d_big) : (used_d >= INDEX_W'(sh_d_n));
        hit_e_new = fixed_mode ? (sh_e_0 == '0 || used_e_big) : (used_e >= INDEX_W'(sh_e_n));

        bytes = cfg.mode_flags[MODE_RANDOM] ? item.random_bytes : cfg.content_size;
        bytes = {bytes[SIZE_W-1:3], 3'b000};
        ub    = {1'b0, used_d} + (INDEX_W+1)'(bytes);

        space_fail_idle = fixed_mode
            ? (INDEX_W'(bytes) > INDEX_W'(sh_d_0) || ub > (INDEX_W+1)'(DCAP))
            : (ub > (INDEX_W+1)'(sh_d_n));
        space_fail_fill = ub > (INDEX_W+1)'(tgt_d_reg);
        rate_ok         = INDEX_W'(item.elapsed_ns) >= threshold;

        phase_next = phase_reg;
        wdp_next   = wdp_reg;
        wdesc_next = wdesc_reg;
        wo_next    = wo_reg;
        cs_next    = cs_reg;
        size_next  = size_reg;
        soff_next  = soff_reg;
        tgt_d_next = tgt_d_reg;
        tgt_e_next = tgt_e_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        pat_next   = pat_reg;
        try_start  = 1'b0;
        from_idle  = 1'b0;
        start      = 1'b0;
        emit_word  = 1'b0;
        emit_desc  = 1'b0;
        has_res    = 1'b0;
        res_next   = '0;
        word       = '0;
        wo_inc     = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (refill_due)
                begin
                    last_next  = item.elapsed_ns;
                    pos_next   = pos_inc;
                    tgt_d_next = fixed_mode ? fixed_d : sh_d_n;
                    tgt_e_next = fixed_mode ? fixed_e : sh_e_n;
                    if (!(hit_d_new || hit_e_new))
                    begin
                        try_start = 1'b1;
                        from_idle = 1'b1;
                    end
                end
            end
            PH_FILL:  try_start = 1'b1;
            PH_WORDS: emit_word = 1'b1;
            PH_DESC:  emit_desc = 1'b1;
            default:  phase_next = PH_IDLE;
        endcase

        space_fail = from_idle ? space_fail_idle : space_fail_fill;
        desc_ok    = from_idle || (used_e < INDEX_W'(tgt_e_reg));

        if (try_start)
        begin
            if (rate_ok && !space_fail && desc_ok)
            begin
                start     = 1'b1;
                size_next = bytes;
                soff_next = wdp_reg;
                wo_next   = '0;
                cs_next   = '0;
                pat_next  = cfg.mode_flags[MODE_RAMP];
                if (cfg.mode_flags[MODE_RAMP] && bytes != '0)
                begin
                    emit_word = 1'b1;
                end
                else
                begin
                    // payload left uninitialized, only the position moves
                    if (!cfg.mode_flags[MODE_RAMP])
                    begin
                        wdp_next = wdp_reg + INDEX_W'(bytes);
                    end
                    emit_desc = 1'b1;
                end
            end
            else
            begin
                phase_next = PH_IDLE;
            end
        end

        eff_wo   = start ? '0 : wo_reg;
        eff_cs   = start ? '0 : cs_reg;
        eff_size = start ? bytes : size_reg;
        eff_soff = start ? wdp_reg : soff_reg;
        eff_pat  = start ? cfg.mode_flags[MODE_RAMP] : pat_reg;

        if (emit_word)
        begin
            word   = {cfg.source_index, 28'd0, eff_wo};
            wo_inc = eff_wo + SIZE_W'(8);
            has_res               = 1'b1;
            res_next.kind         = KIND_WORD;
            res_next.ring_address = ADDR_W'(wdp_reg[DAW-1:0]);
            res_next.data_word    = word;
            cs_next    = eff_cs ^ word[31:0] ^ word[63:32];
            wdp_next   = wdp_reg + INDEX_W'(8);
            wo_next    = wo_inc;
            phase_next = (wo_inc >= eff_size) ? PH_DESC : PH_WORDS;
        end
        else if (emit_desc)
        begin
            has_res                 = 1'b1;
            res_next.kind           = KIND_DESC;
            res_next.ring_address   = ADDR_W'(wdesc_reg[EAW-1:0]);
            res_next.slice_index    = wdesc_reg;
            res_next.checksum       = eff_cs;
            res_next.slice_size     = eff_size;
            res_next.slice_offset   = eff_soff;
            res_next.pattern_format = eff_pat;
            wdesc_next = wdesc_reg + INDEX_W'(1);
            phase_next = PH_FILL;
        end

        if (fire && has_res)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            wdp_reg     <= '0;
            wdesc_reg   <= '0;
            wo_reg      <= '0;
            cs_reg      <= '0;
            size_reg    <= '0;
            soff_reg    <= '0;
            tgt_d_reg   <= '0;
            tgt_e_reg   <= '0;
            last_reg    <= '0;
            pos_reg     <= '0;
            pat_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                phase_reg <= phase_next;
                wdp_reg   <= wdp_next;
                wdesc_reg <= wdesc_next;
                wo_reg    <= wo_next;
                cs_reg    <= cs_next;
                size_reg  <= size_next;
                soff_reg  <= soff_next;
                tgt_d_reg <= tgt_d_next;
                tgt_e_reg <= tgt_e_next;
                last_reg  <= last_next;
                pos_reg   <= pos_next;
                pat_reg   <= pat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && has_res)
        begin
            res_reg <= res_next;
        end
    end

    assign desc_pos  = wdesc_reg;
    assign desc_step = fire && emit_desc;
    assign res_valid = out_vld_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_words_exit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_WORDS |=> phase_reg == PH_WORDS || phase_reg == PH_DESC)
        else $error("word phase left without a descriptor");
    a_desc_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && phase_reg == PH_DESC |=> wdesc_reg == $past(wdesc_reg) + INDEX_W'(1))
        else $error("descriptor emitted without advancing the slot");
    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(wdp_reg) && $stable(wdesc_reg) && $stable(phase_reg))
        else $error("state moved without an accepted word");
    a_word_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && res_reg.kind == KIND_WORD |-> res_reg.slice_index == '0
            && res_reg.checksum == '0 && res_reg.pattern_format == 1'b0)
        else $error("data word carries descriptor fields");
`endif

endmodule

// ===== bench/tb_microslice_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_microslice_pattern_generator_unit
// Self-checking bench for the microslice pattern generator. A clocked driver
// feeds tick words from a queue, a clocked monitor checks every ring write
// against a word-by-word software model of the generator kept in this module.
// ----------------------------------------------------------------------------
module tb_microslice_pattern_generator_unit;

    import msp_pkg::*;

    localparam logic [63:0] DATA_CAP = 64'd1 << 24;
    localparam logic [63:0] DESC_CAP = 64'd1 << 16;
    localparam int          N_PHASES = 12;
    localparam int          PHASE_TICKS = 125;

    typedef enum logic [1:0] {GS_IDLE, GS_FILL, GS_WORDS, GS_DESC} gen_state_e;

    // read indices are either absolute or a fill level behind the write position
    typedef struct {
        logic [ELAPSED_W-1:0] elapsed;
        logic [INDEX_W-1:0]   data_lag;
        logic [INDEX_W-1:0]   desc_lag;
        bit                   relative;
        logic [SIZE_W-1:0]    rnd;
    } tick_plan_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CONTENT_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ELAPSED_W-1:0]  elapsed_ns = '0;
    logic [INDEX_W-1:0]    read_data_index = '0;
    logic [INDEX_W-1:0]    read_desc_index = '0;
    logic [SIZE_W-1:0]     random_bytes = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [ADDR_W-1:0]     ring_address;
    logic [INDEX_W-1:0]    data_word;
    logic [INDEX_W-1:0]    slice_index;
    logic [CSUM_W-1:0]     checksum;
    logic [SIZE_W-1:0]     slice_size;
    logic [INDEX_W-1:0]    slice_offset;
    logic                  pattern_format;

    // register copies
    logic [SIZE_W-1:0]    c_content = RST_CONTENT_SIZE;
    logic [DELAY_W-1:0]   c_delay = RST_DELAY;
    logic [ELAPSED_W-1:0] c_refill = RST_REFILL;
    logic [MODE_W-1:0]    c_mode = RST_MODE;
    logic [SOURCE_W-1:0]  c_source = RST_SOURCE;
    logic [PTABLE_W-1:0]  c_ptable = RST_PCT_TABLE;

    // generator state as predicted
    gen_state_e           gs = GS_IDLE;
    logic [INDEX_W-1:0]   wr_data_pos = '0;
    logic [INDEX_W-1:0]   wr_desc_pos = '0;
    logic [SIZE_W-1:0]    word_ofs = '0;
    logic [CSUM_W-1:0]    csum = '0;
    logic [SIZE_W-1:0]    cur_size = '0;
    logic [INDEX_W-1:0]   slice_start = '0;
    logic [INDEX_W-1:0]   data_target = '0;
    logic [INDEX_W-1:0]   desc_target = '0;
    logic [ELAPSED_W-1:0] last_refill = '0;
    logic [1:0]           pct_pos = '0;
    bit                   slice_ramp = 1'b0;

    tick_plan_t           pending[$];
    msp_res_t             ring_writes_due[$];
    logic [ELAPSED_W-1:0] clock_ns = '0;
    bit                   calm = 1'b0;
    int                   n_errors = 0;
    int                   n_ticks = 0;
    int                   n_words = 0;
    int                   n_descs = 0;
    int                   n_settings = 0;

    microslice_pattern_generator_unit u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .elapsed_ns      (elapsed_ns),
        .read_data_index (read_data_index),
        .read_desc_index (read_desc_index),
        .random_bytes    (random_bytes),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .ring_address    (ring_address),
        .data_word       (data_word),
        .slice_index     (slice_index),
        .checksum        (checksum),
        .slice_size      (slice_size),
        .slice_offset    (slice_offset),
        .pattern_format  (pattern_format)
    );

    always #5 clk = ~clk;

    initial
    begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // generator model
    // ------------------------------------------------------------------------
    function automatic logic [63:0] pct_level(input logic [63:0] cap, input logic [1:0] pos);
        logic [PCT_W-1:0] pct;
        pct = c_ptable[PCT_W*pos +: PCT_W];
        return cap * pct / PCT_DIV;
    endfunction

    // fixed mode: add the first table share to the current use, capped
    function automatic logic [63:0] fixed_level(input logic [63:0] used, input logic [63:0] cap);
        logic [63:0] share;
        share = pct_level(cap, 2'd0);
        if (used >= cap || share > cap - used)
            return cap;
        return used + share;
    endfunction

    function automatic bit try_slice(input logic [ELAPSED_W-1:0] elapsed,
                                     input logic [SIZE_W-1:0] rnd,
                                     input logic [63:0] used_d, input logic [63:0] used_e);
        logic [127:0] lhs;
        logic [127:0] prod;
        logic [63:0]  need;
        logic [63:0]  bytes;
        if (c_delay != '0)
        begin
            lhs = c_delay;
            prod = lhs * wr_desc_pos;
            need = (prod[127:64] != '0) ? '1 : prod[63:0];
            if ({16'b0, elapsed} < need)
                return 1'b0;
        end
        bytes = {44'b0, (c_mode[MODE_RANDOM] ? rnd : c_content) & 20'hFFFF8};
        if (bytes > data_target || used_d > data_target - bytes)
            return 1'b0;
        if (used_e >= desc_target)
            return 1'b0;
        cur_size = bytes[SIZE_W-1:0];
        slice_start = wr_data_pos;
        word_ofs = '0;
        csum = '0;
        slice_ramp = c_mode[MODE_RAMP];
        if (slice_ramp && bytes != '0)
            gs = GS_WORDS;
        else
        begin
            if (!slice_ramp)
                wr_data_pos = wr_data_pos + bytes;
            gs = GS_DESC;
        end
        return 1'b1;
    endfunction

    // one tick of the generator; returns 1 when a ring write is produced
    function automatic bit gen_tick(input msp_item_t it, output msp_res_t wr);
        logic [63:0]          used_d;
        logic [63:0]          used_e;
        logic [ELAPSED_W-1:0] since;
        logic [63:0]          word;
        wr = '0;
        used_d = wr_data_pos - it.read_data_index;
        used_e = wr_desc_pos - it.read_desc_index;
        if (gs == GS_IDLE)
        begin
            since = it.elapsed_ns - last_refill;
            if (since < c_refill)
                return 1'b0;
            last_refill = it.elapsed_ns;
            pct_pos = pct_pos + 2'd1;
            if (c_mode[MODE_FIXED])
            begin
                data_target = fixed_level(used_d, DATA_CAP);
                desc_target = fixed_level(used_e, DESC_CAP);
            end
            else
            begin
                data_target = pct_level(DATA_CAP, pct_pos);
                desc_target = pct_level(DESC_CAP, pct_pos);
            end
            if (used_d >= data_target || used_e >= desc_target)
                return 1'b0;
            gs = GS_FILL;
        end
        if (gs == GS_FILL)
        begin
            if (!try_slice(it.elapsed_ns, it.random_bytes, used_d, used_e))
            begin
                gs = GS_IDLE;
                return 1'b0;
            end
        end
        if (gs == GS_WORDS)
        begin
            word = {c_source, 48'b0} | {44'b0, word_ofs};
            wr.kind = KIND_WORD;
            wr.ring_address = wr_data_pos[ADDR_W-1:0];
            wr.data_word = word;
            csum = csum ^ word[31:0] ^ word[63:32];
            wr_data_pos = wr_data_pos + 64'd8;
            word_ofs = word_ofs + 20'd8;
            if (word_ofs >= cur_size)
                gs = GS_DESC;
            return 1'b1;
        end
        wr.kind = KIND_DESC;
        wr.ring_address = {8'b0, wr_desc_pos[15:0]};
        wr.slice_index = wr_desc_pos;
        wr.checksum = csum;
        wr.slice_size = cur_size;
        wr.slice_offset = slice_start;
        wr.pattern_format = slice_ramp;
        wr_desc_pos = wr_desc_pos + 64'd1;
        gs = GS_FILL;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------------
    tick_plan_t tp_next;
    msp_item_t  tick_in;
    msp_res_t   tick_out;
    int         in_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                tick_in.elapsed_ns = elapsed_ns;
                tick_in.read_data_index = read_data_index;
                tick_in.read_desc_index = read_desc_index;
                tick_in.random_bytes = random_bytes;
                if (gen_tick(tick_in, tick_out))
                    ring_writes_due.push_back(tick_out);
                n_ticks++;
            end
            if (in_gap != 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                tp_next = pending.pop_front();
                in_valid <= 1'b1;
                elapsed_ns <= tp_next.elapsed;
                // model is up to date here, so a lag gives the exact ring use
                read_data_index <= tp_next.relative ? wr_data_pos - tp_next.data_lag
                                                    : tp_next.data_lag;
                read_desc_index <= tp_next.relative ? wr_desc_pos - tp_next.desc_lag
                                                    : tp_next.desc_lag;
                random_bytes <= tp_next.rnd;
                if (!calm && $urandom_range(0, 7) == 0)
                    in_gap = $urandom_range(1, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------------
    msp_res_t want;
    int       out_stall = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;

    task automatic check_field(input string fname, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
            n_errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (ring_writes_due.size() == 0)
                begin
                    $display("%0t: unexpected ring write, expected none, actual kind %0d addr %h",
                             $time, kind, ring_address);
                    n_errors++;
                end
                else
                begin
                    want = ring_writes_due.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("ring_address", want.ring_address, ring_address);
                    check_field("data_word", want.data_word, data_word);
                    check_field("slice_index", want.slice_index, slice_index);
                    check_field("checksum", want.checksum, checksum);
                    check_field("slice_size", want.slice_size, slice_size);
                    check_field("slice_offset", want.slice_offset, slice_offset);
                    check_field("pattern_format", want.pattern_format, pattern_format);
                    if (want.kind == KIND_WORD)
                        n_words++;
                    else
                        n_descs++;
                end
            end
            // one long hold-off while the sender keeps pushing words
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!hold_done && n_words + n_descs >= 300 && pending.size() >= 40)
            begin
                hold_done = 1'b1;
                hold_left = 200;
                out_ready <= 1'b0;
            end
            else if (out_stall != 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall = $urandom_range(0, 2);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic add_tick(input logic [ELAPSED_W-1:0] elapsed, input logic [63:0] dlag,
                            input logic [63:0] elag, input bit relative,
                            input logic [SIZE_W-1:0] rnd);
        tick_plan_t tp;
        tp.elapsed = elapsed;
        tp.data_lag = dlag;
        tp.desc_lag = elag;
        tp.relative = relative;
        tp.rnd = rnd;
        pending.push_back(tp);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_tick(input bit small_rnd);
        logic [63:0]          dlag;
        logic [63:0]          elag;
        logic [63:0]          r64;
        logic [ELAPSED_W-1:0] el;
        logic [SIZE_W-1:0]    rnd;
        int                   sel;
        clock_ns = clock_ns + $urandom_range(0, 40);
        r64 = rand64();
        el = ($urandom_range(0, 15) == 0) ? r64[ELAPSED_W-1:0] : clock_ns;
        rnd = small_rnd ? $urandom_range(0, 1023) : $urandom_range(0, 20'hFFFFF);
        sel = $urandom_range(0, 9);
        if (sel == 0)
            dlag = '0;
        else if (sel < 3)
            dlag = 64'd0;
        else if (sel < 8)
            dlag = $urandom_range(0, 65535);
        else if (sel == 8)
            dlag = $urandom_range(0, 1 << 25);
        else
            dlag = rand64();
        elag = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 70000) : $urandom_range(0, 15);
        // a tenth are absolute noise indices
        if ($urandom_range(0, 9) == 0)
            add_tick(el, rand64(), rand64(), 1'b0, rnd);
        else
            add_tick(el, dlag, elag, 1'b1, rnd);
    endtask

    task automatic apply_settings(input logic [SIZE_W-1:0] content,
                                  input logic [DELAY_W-1:0] delay,
                                  input logic [ELAPSED_W-1:0] refill,
                                  input logic [MODE_W-1:0] mode,
                                  input logic [SOURCE_W-1:0] source,
                                  input logic [PTABLE_W-1:0] ptable);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_CONTENT_SIZE;
        cfg_data <= content;
        c_content = content;
        @(posedge clk);
        cfg_index <= CFG_DELAY;
        cfg_data <= delay;
        c_delay = delay;
        @(posedge clk);
        cfg_index <= CFG_REFILL;
        cfg_data <= refill;
        c_refill = refill;
        @(posedge clk);
        cfg_index <= CFG_MODE;
        cfg_data <= mode;
        c_mode = mode;
        @(posedge clk);
        cfg_index <= CFG_SOURCE;
        cfg_data <= source;
        c_source = source;
        @(posedge clk);
        cfg_index <= CFG_PCT_TABLE;
        cfg_data <= ptable;
        c_ptable = ptable;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        n_settings++;
    endtask

    // everything accepted and answered, then room for words that made no write
    task automatic drain();
        while (pending.size() != 0 || in_valid || ring_writes_due.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        logic [ELAPSED_W-1:0] mark;
        logic [MODE_W-1:0]    mode;
        logic [SIZE_W-1:0]    content;
        logic [DELAY_W-1:0]   delay;
        logic [ELAPSED_W-1:0] refill;
        logic [SOURCE_W-1:0]  source;
        logic [PTABLE_W-1:0]  ptable;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings with a full data ring: refill epochs pass, nothing starts
        add_tick(clock_ns, DATA_CAP, 64'd0, 1'b1, '0);
        add_tick(clock_ns + 48'd3, DATA_CAP, 64'd0, 1'b1, 20'hFFFFF);
        drain();

        // one-word slices with all source bits set
        apply_settings(20'd8, '0, '0, 3'b001, 16'hFFFF, RST_PCT_TABLE);
        repeat (4)
        begin
            clock_ns = clock_ns + 48'd10;
            add_tick(clock_ns, 64'd0, 64'd0, 1'b1, 20'hFFFFF);
        end
        drain();

        // largest size without pattern: data position jumps, no words
        apply_settings(20'hFFFFF, '0, '0, 3'b000, '0, RST_PCT_TABLE);
        add_tick(clock_ns, 64'd0, 64'd0, 1'b1, '0);
        add_tick(clock_ns, 64'd0, 64'd0, 1'b1, '0);
        drain();

        // zero size slice: descriptor at once with zero checksum
        apply_settings('0, '0, '0, 3'b001, 16'h5A5A, RST_PCT_TABLE);
        add_tick(clock_ns, 64'd0, 64'd0, 1'b1, '0);
        add_tick(clock_ns, 64'd0, 64'd0, 1'b1, '0);
        drain();

        // slowest rate: only the largest elapsed time passes
        apply_settings('0, 32'hFFFF_FFFF, '0, 3'b001, 16'h1234, RST_PCT_TABLE);
        add_tick(48'hFFFF_FFFF_FFFF, 64'd0, 64'd0, 1'b1, '0);
        add_tick('0, 64'd0, 64'd0, 1'b1, '0);
        add_tick('0, 64'd0, 64'd0, 1'b1, '0);
        drain();

        // longest refill period, percentages above 100 with use beyond capacity
        apply_settings(20'd8, '0, 48'hFFFF_FFFF_FFFF, 3'b001, '0, 28'hFFF_FFFF);
        mark = last_refill;
        add_tick(mark + 48'd5, DATA_CAP + 64'd100, 64'd0, 1'b1, '0);
        add_tick(mark - 48'd1, DATA_CAP + 64'd100, 64'd0, 1'b1, '0);
        add_tick(mark + 48'd7, DATA_CAP + 64'd100, 64'd0, 1'b1, '0);
        drain();

        // fixed increase saturating at capacity
        apply_settings(20'd16, '0, '0, 3'b101, 16'h8001, 28'hFFF_FFFF);
        repeat (3)
            add_tick(clock_ns, DATA_CAP - 64'd16, 64'd2, 1'b1, '0);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            mode = (p < 8) ? p[MODE_W-1:0] : $urandom_range(0, 7);
            if (!mode[MODE_RAMP] && $urandom_range(0, 2) == 0)
                content = 20'hFFFFF;
            else
                case ($urandom_range(0, 3))
                    0: content = '0;
                    1: content = 20'd8;
                    2: content = $urandom_range(0, 256);
                    default: content = $urandom_range(0, 1023);
                endcase
            if (p == 3)
                delay = 32'hFFFF_FFFF;
            else
                delay = $urandom_range(0, 1) ? '0 : $urandom_range(1, 40);
            if (p == 5)
                refill = 48'hFFFF_FFFF_FFFF;
            else
                refill = ($urandom_range(0, 2) == 0) ? '0 : $urandom_range(1, 400);
            if (p == 1)
                source = 16'hFFFF;
            else if (p == 2)
                source = '0;
            else
                source = $urandom_range(0, 16'hFFFF);
            if (p == 4)
                ptable = 28'hFFF_FFFF;
            else if (p == 6)
                ptable = '0;
            else
                ptable = $urandom_range(0, 28'hFFF_FFFF);
            apply_settings(content, delay, refill, mode, source, ptable);
            if (p == N_PHASES - 1)
                calm <= 1'b1;
            // random sizes stay small where they would become ramp slices
            for (int k = 0; k < PHASE_TICKS; k++)
                random_tick(mode[MODE_RAMP] && mode[MODE_RANDOM]);
            drain();
        end

        $display("%0d tick words over %0d register settings", n_ticks, n_settings);
        $display("%0d data words and %0d descriptors checked", n_words, n_descs);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
